// ===== rtl/core/blk2b_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blk2b_pkg
// Shared types and constants of the BLAKE2b 8-byte digest core: the IV, the
// message schedule, the quarter-G step codes and the working column.
// ----------------------------------------------------------------------------
package blk2b_pkg;

    localparam int BUF_WORDS = 16;
    localparam int BUF_AW    = 4;
    localparam int ROUNDS    = 12;

    // parameter block word 0: digest length 8, key length 0, fanout 1, depth 1
    localparam logic [63:0] PARAM_WORD = 64'h0000_0000_0101_0008;

    localparam logic [63:0] IV [8] = '{
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
        64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
        64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
        64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
    };

    localparam logic [3:0] SIGMA [12][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3}
    };

    // quarter-G steps
    localparam logic [1:0] STEP_ADD_X = 2'd0;
    localparam logic [1:0] STEP_CB_24 = 2'd1;
    localparam logic [1:0] STEP_ADD_Y = 2'd2;
    localparam logic [1:0] STEP_CB_63 = 2'd3;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } col_t;

endpackage
`default_nettype wire

// ===== rtl/core/blk2b_mix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blk2b_mix
// Shared quarter-G unit: one add (three-input for a, two-input for c), one
// xor and one fixed rotate per cycle on the working column a, b, c, d.
// ----------------------------------------------------------------------------
module blk2b_mix (
    input  wire blk2b_pkg::col_t col_in,
    input  wire logic [63:0]     msg,
    input  wire logic [1:0]      step,
    output blk2b_pkg::col_t      col_out
);

    logic [63:0] sum;
    logic [63:0] mixed;

    always_comb
    begin
        col_out = col_in;
        sum     = '0;
        mixed   = '0;
        unique case (step)
            blk2b_pkg::STEP_ADD_X:
            begin
                sum       = col_in.a + col_in.b + msg;
                mixed     = col_in.d ^ sum;
                col_out.a = sum;
                col_out.d = {mixed[31:0], mixed[63:32]};
            end
            blk2b_pkg::STEP_CB_24:
            begin
                sum       = col_in.c + col_in.d;
                mixed     = col_in.b ^ sum;
                col_out.c = sum;
                col_out.b = {mixed[23:0], mixed[63:24]};
            end
            blk2b_pkg::STEP_ADD_Y:
            begin
                sum       = col_in.a + col_in.b + msg;
                mixed     = col_in.d ^ sum;
                col_out.a = sum;
                col_out.d = {mixed[15:0], mixed[63:16]};
            end
            blk2b_pkg::STEP_CB_63:
            begin
                sum       = col_in.c + col_in.d;
                mixed     = col_in.b ^ sum;
                col_out.c = sum;
                col_out.b = {mixed[62:0], mixed[63]};
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/blk2b_msgbuf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blk2b_msgbuf
// Message block buffer: sixteen 64-bit words, one write port and one read
// port with registered read data.
// ----------------------------------------------------------------------------
module blk2b_msgbuf (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [blk2b_pkg::BUF_AW-1:0] wr_addr,
    input  wire logic [63:0]                  wr_data,
    input  wire logic [blk2b_pkg::BUF_AW-1:0] rd_addr,
    output logic [63:0]                       rd_data
);

    logic [63:0] mem [blk2b_pkg::BUF_WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/blake2b_hash_8byte_digest.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blake2b_hash_8byte_digest
// Unkeyed BLAKE2b with an 8-byte digest over a stream of little-endian words.
// ----------------------------------------------------------------------------
// A word that only goes into the block buffer passes the request (ST_IDLE)
// and then one store (ST_DISPATCH). A word that arrives while 16 words are
// buffered, and the last word of a message, each add one compression: a load
// (ST_LOAD), the steps through the single quarter-G unit (ST_COMP: 12 rounds
// of 8 G functions of 4 steps each, one add/xor/rotate a cycle) and a chain
// update (ST_FINISH). A word that waited on a full block then takes one more
// store, and a last word one more state (ST_OUT) to hand the digest to the
// output register once that register is free. The input is not ready while a
// word is stored, a block is compressed or a digest waits in ST_OUT. The
// digest waits in its output register while new message words are taken; the
// following message's digest is held back until the previous one has been taken.
module blake2b_hash_8byte_digest (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // message_word[63:0], byte_count[67:64], zero
    input  wire logic        s_tlast,   // last_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // digest[63:0]
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_LOAD     = 3'd2;
    localparam logic [2:0] ST_COMP     = 3'd3;
    localparam logic [2:0] ST_FINISH   = 3'd4;
    localparam logic [2:0] ST_OUT      = 3'd5;

    localparam logic [4:0] FULL_WORDS  = 5'(blk2b_pkg::BUF_WORDS);
    localparam logic [3:0] LAST_ROUND  = 4'(blk2b_pkg::ROUNDS - 1);

    logic [2:0]        state_reg;
    logic [3:0]        round_reg;
    logic [2:0]        g_reg;
    logic [1:0]        step_reg;
    logic [4:0]        words_reg;
    logic [63:0]       total_reg;
    logic              final_reg;
    logic [7:0][63:0]  h_reg;
    logic [15:0][63:0] v_reg;
    logic [15:0][63:0] v_next;
    logic [63:0]       pend_word_reg;
    logic [3:0]        pend_nb_reg;
    logic              pend_last_reg;
    logic              live_reg;
    logic [63:0]       m_tdata_reg;
    logic              m_tvalid_reg;

    logic              in_fire;
    logic [3:0]        in_nb;
    logic              wr_en;
    logic [63:0]       wr_data;
    logic [3:0]        rd_addr;
    logic [63:0]       rd_data;
    logic [63:0]       msg_word;
    logic [3:0]        nx_round;
    logic [2:0]        nx_g;
    logic              out_free;
    blk2b_pkg::col_t   col_in;
    blk2b_pkg::col_t   col_out;

    function automatic logic [63:0] byte_mask(input logic [3:0] nb);
        logic [63:0] m;
        if (nb[3])
        begin
            m = '1;
        end
        else
        begin
            m = ~({64{1'b1}} << {nb[2:0], 3'b000});
        end
        return m;
    endfunction

    function automatic logic [3:0][63:0] rot_row(input logic [3:0][63:0] row,
                                                 input logic [1:0]       k);
        logic [3:0][63:0] r;
        logic [1:0]       idx;
        for (int i = 0; i < 4; i++)
        begin
            idx  = 2'(i) + k;
            r[i] = row[idx];
        end
        return r;
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_nb    = (!s_tlast || (s_tdata[67:64] > 4'd8)) ? 4'd8 : s_tdata[67:64];
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // stores happen only while the block still has room
    assign wr_en   = (state_reg == ST_DISPATCH) && !words_reg[4];
    assign wr_data = pend_word_reg & byte_mask(pend_nb_reg);

    // message schedule: each word is fetched in the cycle before its add step
    always_comb
    begin
        nx_g     = g_reg + 3'd1;
        nx_round = round_reg;
        if (g_reg == 3'd7)
        begin
            nx_round = (round_reg == LAST_ROUND) ? 4'd0 : round_reg + 4'd1;
        end
        if (state_reg == ST_LOAD)
        begin
            rd_addr = blk2b_pkg::SIGMA[0][0];
        end
        else if (step_reg == blk2b_pkg::STEP_CB_24)
        begin
            rd_addr = blk2b_pkg::SIGMA[round_reg][{g_reg, 1'b1}];
        end
        else
        begin
            rd_addr = blk2b_pkg::SIGMA[nx_round][{nx_g, 1'b0}];
        end
    end

    blk2b_msgbuf u_msgbuf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (words_reg[3:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // words past the fill level read as zero padding
    assign msg_word = live_reg ? rd_data : '0;

    assign col_in.a = v_reg[0];
    assign col_in.b = v_reg[4];
    assign col_in.c = v_reg[8];
    assign col_in.d = v_reg[12];

    blk2b_mix u_mix (
        .col_in  (col_in),
        .msg     (msg_word),
        .step    (step_reg),
        .col_out (col_out)
    );

    // after each G the rows rotate so the next column or diagonal sits at
    // column 0; the last column G diagonalizes, the last diagonal G undoes it
    always_comb
    begin
        logic [15:0][63:0] t;
        logic [1:0]        k;
        k     = 2'd0;
        t     = v_reg;
        t[0]  = col_out.a;
        t[4]  = col_out.b;
        t[8]  = col_out.c;
        t[12] = col_out.d;
        v_next = t;
        if (step_reg == blk2b_pkg::STEP_CB_63)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (g_reg == 3'd3)
                begin
                    k = 2'(r + 1);
                end
                else if (g_reg == 3'd7)
                begin
                    k = 2'(1 - r);
                end
                else
                begin
                    k = 2'd1;
                end
                v_next[4*r +: 4] = rot_row(t[4*r +: 4], k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            round_reg    <= '0;
            g_reg        <= '0;
            step_reg     <= '0;
            words_reg    <= '0;
            total_reg    <= '0;
            final_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 1; i < 8; i++)
            begin
                h_reg[i] <= blk2b_pkg::IV[i];
            end
            h_reg[0] <= blk2b_pkg::IV[0] ^ blk2b_pkg::PARAM_WORD;
        end
        else
        begin
            if ((state_reg == ST_OUT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH:
                begin
                    priority if (pend_last_reg && (pend_nb_reg == 4'd0) && words_reg[4])
                    begin
                        // empty last word: the full block is the final one
                        final_reg <= 1'b1;
                        state_reg <= ST_LOAD;
                    end
                    else if (words_reg[4])
                    begin
                        final_reg <= 1'b0;
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        words_reg <= words_reg + 5'd1;
                        total_reg <= total_reg + 64'(pend_nb_reg);
                        final_reg <= pend_last_reg;
                        state_reg <= pend_last_reg ? ST_LOAD : ST_IDLE;
                    end
                end
                ST_LOAD:
                begin
                    round_reg <= '0;
                    g_reg     <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_COMP;
                end
                ST_COMP:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == blk2b_pkg::STEP_CB_63)
                    begin
                        g_reg <= nx_g;
                        if (g_reg == 3'd7)
                        begin
                            round_reg <= nx_round;
                            if (round_reg == LAST_ROUND)
                            begin
                                state_reg <= ST_FINISH;
                            end
                        end
                    end
                end
                ST_FINISH:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] ^ v_reg[i] ^ v_reg[i + 8];
                    end
                    if (final_reg)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        // block flushed, now store the waiting word
                        words_reg <= '0;
                        state_reg <= ST_DISPATCH;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        words_reg    <= '0;
                        total_reg    <= '0;
                        final_reg    <= 1'b0;
                        for (int i = 1; i < 8; i++)
                        begin
                            h_reg[i] <= blk2b_pkg::IV[i];
                        end
                        h_reg[0]  <= blk2b_pkg::IV[0] ^ blk2b_pkg::PARAM_WORD;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        live_reg <= ({1'b0, rd_addr} < words_reg);
        if (in_fire)
        begin
            pend_word_reg <= s_tdata[63:0];
            pend_nb_reg   <= in_nb;
            pend_last_reg <= s_tlast;
        end
        if (state_reg == ST_LOAD)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
                if ((i != 4) && (i != 6))
                begin
                    v_reg[i + 8] <= blk2b_pkg::IV[i];
                end
            end
            v_reg[12] <= blk2b_pkg::IV[4] ^ total_reg;
            v_reg[14] <= final_reg ? ~blk2b_pkg::IV[6] : blk2b_pkg::IV[6];
        end
        else if (state_reg == ST_COMP)
        begin
            v_reg <= v_next;
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            m_tdata_reg <= h_reg[0];
        end
    end

`ifndef SYNTH
    a_words_range: assert property (@(posedge clk) disable iff (!rst_n)
        words_reg <= FULL_WORDS)
        else $error("block fill level beyond 16 words");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP) |-> (round_reg <= LAST_ROUND))
        else $error("round counter out of range during compression");

    a_finish_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP) && (round_reg == LAST_ROUND) && (g_reg == 3'd7)
        && (step_reg == blk2b_pkg::STEP_CB_63) |=> (state_reg == ST_FINISH))
        else $error("compression did not end after the last quarter-G step");

    a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DISPATCH) && !wr_en |=> (state_reg == ST_LOAD))
        else $error("full block not flushed before storing a word");

    a_digest_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_OUT) && !$past(final_reg == 1'b0))
        else $error("digest issued outside the final block");
`endif

endmodule
`default_nettype wire
